/* rtl/core/blit_clip_descriptor_macros.svh */
// assertion macros for the blit clip descriptor checker
// expects clk and arst_n in the scope of each use
`ifndef BLIT_CLIP_DESCRIPTOR_MACROS_SVH
`define BLIT_CLIP_DESCRIPTOR_MACROS_SVH

// consequent checked in the same cycle
`define BCD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("blit clip descriptor check failed");

// consequent checked in the next cycle
`define BCD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("blit clip descriptor check failed");

`endif

/* rtl/core/bcd_pkg.sv */
// shared types, widths and codes for the blit clip descriptor
// no dependencies
package bcd_pkg;

	localparam int ADDR_W     = 32;
	localparam int CRD_W      = 16;
	localparam int EXT_W      = CRD_W + 2;
	localparam int DIM_W      = 12;
	localparam int PITCH_W    = 16;
	localparam int BPP_W      = 6;
	localparam int FMT_W      = 4;
	localparam int BYTES_W    = BPP_W - 3;
	localparam int ROWB_W     = 14;
	localparam int STAT_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_W    = 2;

	localparam int REQ_W = ADDR_W + PITCH_W + BPP_W + FMT_W + 6 * CRD_W;
	localparam int IN_W  = ((REQ_W + 7) / 8) * 8;
	localparam int RES_W = STAT_W + 2 * ADDR_W + ROWB_W + DIM_W + 2 * PITCH_W;
	localparam int OUT_W = ((RES_W + 7) / 8) * 8;

	localparam logic [STAT_W-1:0] ST_COPY    = 2'd0;
	localparam logic [STAT_W-1:0] ST_REJECT  = 2'd1;
	localparam logic [STAT_W-1:0] ST_NO_COPY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_DST_BASE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DST_PITCH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DST_BPP    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DST_FORMAT = 3'd5;

	localparam logic [BPP_W-1:0] BPP_16 = 6'd16;
	localparam logic [BPP_W-1:0] BPP_32 = 6'd32;

	typedef struct packed {
		logic signed [CRD_W-1:0] rect_h;
		logic signed [CRD_W-1:0] rect_w;
		logic signed [CRD_W-1:0] src_y;
		logic signed [CRD_W-1:0] src_x;
		logic signed [CRD_W-1:0] dest_y;
		logic signed [CRD_W-1:0] dest_x;
		logic [FMT_W-1:0]        src_format;
		logic [BPP_W-1:0]        src_bpp;
		logic [PITCH_W-1:0]      src_pitch;
		logic [ADDR_W-1:0]       src_base;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  dst_base;
		logic [PITCH_W-1:0] dst_pitch;
		logic [DIM_W-1:0]   dst_width;
		logic [DIM_W-1:0]   dst_height;
		logic [BPP_W-1:0]   dst_bpp;
		logic [FMT_W-1:0]   dst_format;
	} cfg_t;

	typedef struct packed {
		logic                    reject;
		logic                    mismatch;
		logic [ADDR_W-1:0]       s_base;
		logic [PITCH_W-1:0]      s_pitch;
		logic [BYTES_W-1:0]      s_bytes;
		logic [BYTES_W-1:0]      d_bytes;
		logic signed [EXT_W-1:0] sx;
		logic signed [EXT_W-1:0] sy;
		logic [DIM_W-1:0]        dx;
		logic [DIM_W-1:0]        dy;
		logic [DIM_W-1:0]        w;
		logic [DIM_W-1:0]        h;
	} desc_t;

	typedef struct packed {
		logic [PITCH_W-1:0] dst_stride;
		logic [PITCH_W-1:0] src_stride;
		logic [DIM_W-1:0]   row_count;
		logic [ROWB_W-1:0]  row_bytes;
		logic [ADDR_W-1:0]  dst_addr;
		logic [ADDR_W-1:0]  src_addr;
		logic [STAT_W-1:0]  status;
	} res_t;

endpackage

/* rtl/core/bcd_front.sv */
// front end: takes requests, clips against the target surface, classifies
// depends on bcd_pkg
module bcd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bcd_pkg::req_t in_req,
	input  bcd_pkg::cfg_t cfg,
	output logic          push_valid,
	input  logic          push_ready,
	output bcd_pkg::desc_t push_desc
);

	logic signed [bcd_pkg::EXT_W-1:0] dx_e, dy_e, sx_e, sy_e, w_e, h_e, tw_e, th_e;
	logic signed [bcd_pkg::EXT_W-1:0] w1, h1, w2, h2, w3, h3, sx2, sy2, dx2, dy2;
	logic signed [bcd_pkg::EXT_W-1:0] rem_w, rem_h;
	logic           bpp_ok, reject0, reject;
	bcd_pkg::desc_t desc_d, desc_s1;
	logic           valid_s1;

	always_comb begin
		dx_e = bcd_pkg::EXT_W'(in_req.dest_x);
		dy_e = bcd_pkg::EXT_W'(in_req.dest_y);
		sx_e = bcd_pkg::EXT_W'(in_req.src_x);
		sy_e = bcd_pkg::EXT_W'(in_req.src_y);
		w_e  = bcd_pkg::EXT_W'(in_req.rect_w);
		h_e  = bcd_pkg::EXT_W'(in_req.rect_h);
		tw_e = $signed(bcd_pkg::EXT_W'(cfg.dst_width));
		th_e = $signed(bcd_pkg::EXT_W'(cfg.dst_height));

		bpp_ok  = (cfg.dst_bpp == bcd_pkg::BPP_16) || (cfg.dst_bpp == bcd_pkg::BPP_32);
		reject0 = (w_e <= 0) || (h_e <= 0) || (dy_e >= th_e) || (dx_e >= tw_e) || !bpp_ok;

		rem_w = tw_e - dx_e;
		rem_h = th_e - dy_e;
		w1 = (rem_w < w_e) ? rem_w : w_e;
		h1 = (rem_h < h_e) ? rem_h : h_e;

		if (dx_e < 0) begin
			sx2 = sx_e - dx_e;
			w2  = w1 + dx_e;
			dx2 = '0;
		end else begin
			sx2 = sx_e;
			w2  = w1;
			dx2 = dx_e;
		end
		if (dy_e < 0) begin
			sy2 = sy_e - dy_e;
			h2  = h1 + dy_e;
			dy2 = '0;
		end else begin
			sy2 = sy_e;
			h2  = h1;
			dy2 = dy_e;
		end

		w3 = ((dx2 + w2) > tw_e) ? (tw_e - dx2) : w2;
		h3 = ((dy2 + h2) > th_e) ? (th_e - dy2) : h2;

		reject = reject0 || (w3 <= 0) || (h3 <= 0);

		desc_d.reject   = reject;
		desc_d.mismatch = (cfg.dst_bpp != in_req.src_bpp) || (cfg.dst_format != in_req.src_format);
		desc_d.s_base   = in_req.src_base;
		desc_d.s_pitch  = in_req.src_pitch;
		desc_d.s_bytes  = in_req.src_bpp[bcd_pkg::BPP_W-1:3];
		desc_d.d_bytes  = cfg.dst_bpp[bcd_pkg::BPP_W-1:3];
		desc_d.sx       = sx2;
		desc_d.sy       = sy2;
		desc_d.dx       = dx2[bcd_pkg::DIM_W-1:0];
		desc_d.dy       = dy2[bcd_pkg::DIM_W-1:0];
		desc_d.w        = w3[bcd_pkg::DIM_W-1:0];
		desc_d.h        = h3[bcd_pkg::DIM_W-1:0];
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_desc  = desc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			desc_s1 <= desc_d;
		end
	end

endmodule

/* rtl/core/bcd_queue.sv */
// short descriptor queue between the clipping front end and the address back end
// depends on bcd_pkg
module bcd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  bcd_pkg::desc_t push_desc,
	output logic           pop_valid,
	input  logic           pop_ready,
	output bcd_pkg::desc_t pop_desc
);

	bcd_pkg::desc_t                mem_q [bcd_pkg::Q_DEPTH];
	logic [bcd_pkg::Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [bcd_pkg::Q_PTR_W:0]     count_q;
	logic                          do_push, do_pop;

	assign push_ready = count_q != (bcd_pkg::Q_PTR_W + 1)'(bcd_pkg::Q_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_desc   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

endmodule

/* rtl/core/bcd_back.sv */
// back end: address products, then sums and the result register
// depends on bcd_pkg
module bcd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  bcd_pkg::cfg_t  cfg,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  bcd_pkg::desc_t pop_desc,
	output logic           out_valid,
	input  logic           out_ready,
	output bcd_pkg::res_t  out_res
);

	logic signed [bcd_pkg::PITCH_W:0]               s_pitch_sg;
	logic signed [bcd_pkg::BYTES_W:0]               s_bytes_sg;
	logic signed [bcd_pkg::EXT_W-1:0]               sx_sg, sy_sg;
	logic signed [bcd_pkg::PITCH_W+bcd_pkg::EXT_W:0] src_row_p;
	logic signed [bcd_pkg::BYTES_W+bcd_pkg::EXT_W:0] src_col_p;
	logic [bcd_pkg::PITCH_W+bcd_pkg::DIM_W-1:0]     dst_row_p;
	logic [bcd_pkg::DIM_W+bcd_pkg::BYTES_W-1:0]     dst_col_p, row_bytes_p;

	logic                          valid_s1, valid_s2, adv, en1;
	logic                          reject_s1, mismatch_s1;
	logic [bcd_pkg::ADDR_W-1:0]    s_base_s1, src_row_s1, src_col_s1, dst_row_s1, dst_col_s1;
	logic [bcd_pkg::PITCH_W-1:0]   s_pitch_s1;
	logic [bcd_pkg::ROWB_W-1:0]    row_bytes_s1;
	logic [bcd_pkg::DIM_W-1:0]     h_s1;
	bcd_pkg::res_t                 res_d, res_s2;

	assign adv       = !valid_s2 || out_ready;
	assign en1       = !valid_s1 || adv;
	assign pop_ready = en1;

	always_comb begin
		s_pitch_sg  = $signed({1'b0, pop_desc.s_pitch});
		s_bytes_sg  = $signed({1'b0, pop_desc.s_bytes});
		sx_sg       = pop_desc.sx;
		sy_sg       = pop_desc.sy;
		src_row_p   = s_pitch_sg * sy_sg;
		src_col_p   = s_bytes_sg * sx_sg;
		dst_row_p   = cfg.dst_pitch * pop_desc.dy;
		dst_col_p   = pop_desc.dx * pop_desc.d_bytes;
		row_bytes_p = pop_desc.w * pop_desc.d_bytes;
	end

	always_comb begin
		res_d = '0;
		if (reject_s1) begin
			res_d.status = bcd_pkg::ST_REJECT;
		end else begin
			res_d.status     = mismatch_s1 ? bcd_pkg::ST_NO_COPY : bcd_pkg::ST_COPY;
			res_d.src_addr   = s_base_s1 + src_row_s1 + src_col_s1;
			res_d.dst_addr   = cfg.dst_base + dst_row_s1 + dst_col_s1;
			res_d.row_bytes  = row_bytes_s1;
			res_d.row_count  = h_s1;
			res_d.src_stride = s_pitch_s1;
			res_d.dst_stride = cfg.dst_pitch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= pop_valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && pop_valid) begin
			reject_s1    <= pop_desc.reject;
			mismatch_s1  <= pop_desc.mismatch;
			s_base_s1    <= pop_desc.s_base;
			s_pitch_s1   <= pop_desc.s_pitch;
			h_s1         <= pop_desc.h;
			src_row_s1   <= bcd_pkg::ADDR_W'(src_row_p);
			src_col_s1   <= bcd_pkg::ADDR_W'(src_col_p);
			dst_row_s1   <= bcd_pkg::ADDR_W'(dst_row_p);
			dst_col_s1   <= bcd_pkg::ADDR_W'(dst_col_p);
			row_bytes_s1 <= bcd_pkg::ROWB_W'(row_bytes_p);
		end
		if (adv && valid_s1) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_res   = res_s2;

endmodule

/* rtl/core/blit_clip_descriptor.sv */
// blit clip descriptor top level: config registers, front end, queue, back end
// depends on bcd_pkg, bcd_front, bcd_queue, bcd_back
//
// Takes one blit request per clock while s_tready is high and returns one copy
// descriptor for each, in order. A request is clipped in a single front stage,
// parked in a four-entry queue, and finished in a two-stage address pipeline
// (products, then sums); it is registered in each of these before it shows on
// m_tvalid, and a stalled output backs up into the queue before s_tready drops.
// Configuration writes are always ready and take effect on the next request;
// change them only while no request is in flight.
module blit_clip_descriptor (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// src_base, src_pitch, src_bpp, src_format, dest_x, dest_y, src_x, src_y,
	// rect_w, rect_h, zero pad
	input  logic [bcd_pkg::IN_W-1:0]          s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// status, src_addr, dst_addr, row_bytes, row_count, src_stride, dst_stride,
	// zero pad
	output logic [bcd_pkg::OUT_W-1:0]         m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bcd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bcd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	bcd_pkg::cfg_t  cfg_q;
	bcd_pkg::req_t  req;
	bcd_pkg::desc_t push_desc, pop_desc;
	bcd_pkg::res_t  res;
	logic           push_valid, push_ready, pop_valid, pop_ready;

	assign cfg_ready = 1'b1;
	assign req       = bcd_pkg::req_t'(s_tdata[bcd_pkg::REQ_W-1:0]);
	assign m_tdata   = bcd_pkg::OUT_W'(res);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bcd_pkg::REG_DST_BASE: begin
					cfg_q.dst_base <= cfg_data[bcd_pkg::ADDR_W-1:0];
				end
				bcd_pkg::REG_DST_PITCH: begin
					cfg_q.dst_pitch <= cfg_data[bcd_pkg::PITCH_W-1:0];
				end
				bcd_pkg::REG_DST_WIDTH: begin
					cfg_q.dst_width <= cfg_data[bcd_pkg::DIM_W-1:0];
				end
				bcd_pkg::REG_DST_HEIGHT: begin
					cfg_q.dst_height <= cfg_data[bcd_pkg::DIM_W-1:0];
				end
				bcd_pkg::REG_DST_BPP: begin
					cfg_q.dst_bpp <= cfg_data[bcd_pkg::BPP_W-1:0];
				end
				bcd_pkg::REG_DST_FORMAT: begin
					cfg_q.dst_format <= cfg_data[bcd_pkg::FMT_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	bcd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_req     (req),
		.cfg        (cfg_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc)
	);

	bcd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_desc   (pop_desc)
	);

	bcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_desc  (pop_desc),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

endmodule

/* rtl/core/bcd_checker.sv */
// port-level checks on the blit clip descriptor output, bound to the top level
// depends on bcd_pkg and blit_clip_descriptor_macros.svh
`include "blit_clip_descriptor_macros.svh"

module bcd_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [bcd_pkg::OUT_W-1:0] m_tdata
);

	bcd_pkg::res_t res;

	assign res = bcd_pkg::res_t'(m_tdata[bcd_pkg::RES_W-1:0]);

	`BCD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`BCD_ASSERT_NOW(a_status_code, m_tvalid, res.status == bcd_pkg::ST_COPY || res.status == bcd_pkg::ST_REJECT || res.status == bcd_pkg::ST_NO_COPY)
	`BCD_ASSERT_NOW(a_reject_empty, m_tvalid && res.status == bcd_pkg::ST_REJECT, m_tdata[bcd_pkg::OUT_W-1:bcd_pkg::STAT_W] == '0)
	`BCD_ASSERT_NOW(a_copy_nonempty, m_tvalid && res.status != bcd_pkg::ST_REJECT, res.row_count != '0 && res.row_bytes != '0)

endmodule

bind blit_clip_descriptor bcd_checker u_bcd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

/* tb/tb_blit_clip_descriptor.sv */
// testbench for blit_clip_descriptor: directed and random blit requests under several
// target settings, each descriptor checked field by field against a clipping predictor
// depends on bcd_pkg and blit_clip_descriptor
module tb_blit_clip_descriptor;
	import bcd_pkg::*;

	localparam int HOLD_OFF_CYCLES = 60;

	class descriptor_board;
		cfg_t target = '0;
		res_t due_descriptors[$];
		int errors = 0;
		int checked = 0;
		int copies = 0;
		int no_copies = 0;
		int rejects = 0;

		function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
			case (index)
				REG_DST_BASE: target.dst_base = value[ADDR_W-1:0];
				REG_DST_PITCH: target.dst_pitch = value[PITCH_W-1:0];
				REG_DST_WIDTH: target.dst_width = value[DIM_W-1:0];
				REG_DST_HEIGHT: target.dst_height = value[DIM_W-1:0];
				REG_DST_BPP: target.dst_bpp = value[BPP_W-1:0];
				REG_DST_FORMAT: target.dst_format = value[FMT_W-1:0];
				default: ;
			endcase
		endfunction

		function res_t clip_descriptor(req_t r);
			res_t d;
			longint dx, dy, sx, sy, w, h, tw, th;
			logic [63:0] sa, da;
			bit drop;
			d = '0;
			dx = $signed(r.dest_x);
			dy = $signed(r.dest_y);
			sx = $signed(r.src_x);
			sy = $signed(r.src_y);
			w = $signed(r.rect_w);
			h = $signed(r.rect_h);
			tw = target.dst_width;
			th = target.dst_height;
			drop = (w <= 0 || h <= 0 || dy >= th || dx >= tw ||
				!(target.dst_bpp == BPP_16 || target.dst_bpp == BPP_32));
			if (!drop) begin
				if (tw - dx < w) w = tw - dx;
				if (th - dy < h) h = th - dy;
				if (dx < 0) begin
					sx -= dx;
					w += dx;
					dx = 0;
				end
				if (dy < 0) begin
					sy -= dy;
					h += dy;
					dy = 0;
				end
				if (dx + w > tw) w = tw - dx;
				if (dy + h > th) h = th - dy;
				drop = (w <= 0 || h <= 0);
			end
			if (drop) begin
				d.status = ST_REJECT;
				return d;
			end
			d.status = (target.dst_bpp == r.src_bpp && target.dst_format == r.src_format) ?
				ST_COPY : ST_NO_COPY;
			sa = 64'(r.src_base) + 64'(r.src_pitch) * 64'(sy) + 64'(sx) * 64'(r.src_bpp >> 3);
			da = 64'(target.dst_base) + 64'(target.dst_pitch) * 64'(dy) +
				64'(dx) * 64'(target.dst_bpp >> 3);
			d.src_addr = sa[ADDR_W-1:0];
			d.dst_addr = da[ADDR_W-1:0];
			d.row_bytes = ROWB_W'(w * longint'(target.dst_bpp >> 3));
			d.row_count = DIM_W'(h);
			d.src_stride = r.src_pitch;
			d.dst_stride = target.dst_pitch;
			return d;
		endfunction

		function void note_request(req_t r);
			due_descriptors.push_back(clip_descriptor(r));
		endfunction

		function void compare_field(string field, longint unsigned want, longint unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			end
		endfunction

		function void check_descriptor(res_t got);
			res_t want;
			if (due_descriptors.size() == 0) begin
				errors++;
				$display("%0t: unexpected descriptor, expected none, actual %h", $time, got);
				return;
			end
			want = due_descriptors.pop_front();
			checked++;
			compare_field("status", want.status, got.status);
			compare_field("src_addr", want.src_addr, got.src_addr);
			compare_field("dst_addr", want.dst_addr, got.dst_addr);
			compare_field("row_bytes", want.row_bytes, got.row_bytes);
			compare_field("row_count", want.row_count, got.row_count);
			compare_field("src_stride", want.src_stride, got.src_stride);
			compare_field("dst_stride", want.dst_stride, got.dst_stride);
			case (want.status)
				ST_COPY: copies++;
				ST_NO_COPY: no_copies++;
				default: rejects++;
			endcase
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	descriptor_board board = new;
	cfg_t tgt = '0;
	bit hold_off_req = 1'b0;
	int accepted = 0;
	int settings = 0;

	blit_clip_descriptor dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (cfg_valid && cfg_ready)
			board.set_reg(cfg_index, cfg_data);
		if (s_tvalid && s_tready) begin
			board.note_request(req_t'(s_tdata[$bits(req_t)-1:0]));
			accepted++;
		end
		if (m_tvalid && m_tready)
			board.check_descriptor(res_t'(m_tdata[$bits(res_t)-1:0]));
	end

	// receiver stall pattern, with a long hold-off when one is requested
	initial begin
		int left;
		int mode;
		left = 0;
		mode = 0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(8, 64);
				end
				left--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 1) == 0);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	initial begin
		#5_000_000;
		$display("FAIL blit_clip_descriptor");
		$finish;
	end

	function automatic req_t blit(logic [31:0] base, int pitch, int bpp, int fmt, int dx,
		int dy, int sx, int sy, int w, int h);
		req_t r;
		r.src_base = base;
		r.src_pitch = PITCH_W'(pitch);
		r.src_bpp = BPP_W'(bpp);
		r.src_format = FMT_W'(fmt);
		r.dest_x = CRD_W'(dx);
		r.dest_y = CRD_W'(dy);
		r.src_x = CRD_W'(sx);
		r.src_y = CRD_W'(sy);
		r.rect_w = CRD_W'(w);
		r.rect_h = CRD_W'(h);
		return r;
	endfunction

	function automatic req_t random_request(cfg_t t);
		req_t r;
		int tw;
		int th;
		tw = t.dst_width;
		th = t.dst_height;
		r.src_base = $urandom;
		r.src_pitch = PITCH_W'($urandom);
		r.src_x = CRD_W'($urandom);
		r.src_y = CRD_W'($urandom);
		if ($urandom_range(0, 9) < 7) begin
			r.src_bpp = ($urandom_range(0, 7) == 0) ? BPP_W'($urandom) : t.dst_bpp;
			r.src_format = ($urandom_range(0, 7) == 0) ? FMT_W'($urandom) : t.dst_format;
			r.dest_x = CRD_W'($urandom_range(0, tw + 160) - 128);
			r.dest_y = CRD_W'($urandom_range(0, th + 160) - 128);
			r.rect_w = ($urandom_range(0, 15) == 0) ? CRD_W'($urandom_range(1, 32767)) :
				CRD_W'($urandom_range(1, 300));
			r.rect_h = ($urandom_range(0, 15) == 0) ? CRD_W'($urandom_range(1, 32767)) :
				CRD_W'($urandom_range(1, 300));
		end else begin
			r.src_bpp = BPP_W'($urandom);
			r.src_format = FMT_W'($urandom);
			r.dest_x = CRD_W'($urandom);
			r.dest_y = CRD_W'($urandom);
			r.rect_w = CRD_W'($urandom);
			r.rect_h = CRD_W'($urandom);
		end
		return r;
	endfunction

	task automatic send_request(req_t r);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= IN_W'(r);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic close_stream();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic drain();
		while (board.due_descriptors.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// upper bits of the narrow registers carry noise
	task automatic program_target(logic [31:0] base, logic [15:0] pitch, logic [11:0] width,
		logic [11:0] height, logic [5:0] bpp, logic [3:0] fmt);
		logic [31:0] word;
		drain();
		tgt = '{dst_base: base, dst_pitch: pitch, dst_width: width, dst_height: height,
			dst_bpp: bpp, dst_format: fmt};
		write_reg(REG_DST_BASE, base);
		word = $urandom;
		word[15:0] = pitch;
		write_reg(REG_DST_PITCH, word);
		word = $urandom;
		word[11:0] = width;
		write_reg(REG_DST_WIDTH, word);
		word = $urandom;
		word[11:0] = height;
		write_reg(REG_DST_HEIGHT, word);
		word = $urandom;
		word[5:0] = bpp;
		write_reg(REG_DST_BPP, word);
		word = $urandom;
		word[3:0] = fmt;
		write_reg(REG_DST_FORMAT, word);
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	task automatic run_phase(int count, bit steady);
		int burst;
		int gap;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			if (!steady && burst == 0) begin
				burst = $urandom_range(1, 16);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				repeat (gap) begin
					@(negedge clk);
					s_tvalid <= 1'b0;
				end
			end
			if (burst > 0) burst--;
			send_request(random_request(tgt));
		end
		close_stream();
	endtask

	initial begin
		logic [11:0] wd;
		logic [11:0] ht;
		logic [5:0] depth;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// registers still at reset values
		send_request(blit(32'h100, 64, 32, 0, 0, 0, 0, 0, 4, 4));
		send_request('1);
		close_stream();

		program_target(32'hFFFF_FF00, 16'hFFFF, 12'd640, 12'd480, BPP_32, 4'd5);
		send_request(blit(32'h0001_0000, 2560, 32, 5, 0, 0, 10, 20, 100, 50));
		send_request(blit(32'h0001_0000, 2560, 32, 5, -30, 7, 5, 5, 100, 10));
		send_request(blit(32'h0040_0000, 1280, 32, 5, 12, -40, 0, 0, 16, 64));
		send_request(blit(32'h0, 65535, 32, 5, -5, -6, -32768, -32768, 20, 20));
		send_request(blit(32'h1000, 100, 32, 5, 639, 479, 3, 3, 10, 10));
		send_request(blit(32'h1000, 100, 32, 5, 640, 0, 0, 0, 1, 1));
		send_request(blit(32'h1000, 100, 32, 5, 0, 480, 0, 0, 1, 1));
		send_request(blit(32'h1000, 100, 32, 5, 10, 10, 0, 0, 0, 5));
		send_request(blit(32'h1000, 100, 32, 5, 10, 10, 0, 0, 5, -32768));
		send_request(blit(32'h1000, 100, 32, 5, 10, 10, 0, 0, -1, 5));
		send_request(blit(32'h1000, 100, 32, 5, -100, 0, 0, 0, 50, 5));
		send_request(blit(32'h1000, 100, 32, 5, -100, 0, 0, 0, 100, 5));
		send_request(blit(32'h1000, 100, 32, 5, -32768, -32768, 0, 0, 32767, 32767));
		send_request(blit(32'h2000, 4096, 32, 5, 0, 0, 0, 0, 32767, 32767));
		send_request(blit(32'h2000, 4096, 16, 5, 3, 4, 5, 6, 7, 8));
		send_request(blit(32'h2000, 4096, 32, 6, 3, 4, 5, 6, 7, 8));
		send_request(blit(32'h2000, 4096, 24, 5, 3, 4, 5, 6, 7, 8));
		send_request(blit(32'h2000, 4096, 63, 15, 3, 4, -5, -6, 7, 8));
		send_request(blit(32'hFFFF_FFFF, 65535, 32, 5, 1, 1, 32767, 32767, 5, 5));
		send_request(blit(32'h2000, 4096, 32, 5, 32767, 32767, 0, 0, 1, 1));
		send_request(blit(32'h0, 0, 0, 0, -1, -1, 0, 0, 2, 2));
		close_stream();

		program_target(32'hFFFF_FFFF, 16'hFFFF, 12'd4095, 12'd4095, BPP_32, 4'd15);
		run_phase(160, 1'b0);
		program_target(32'h0, 16'h0, 12'd4095, 12'd4095, BPP_16, 4'd0);
		run_phase(160, 1'b0);
		program_target(32'h1234_5678, 16'd320, 12'd0, 12'd0, BPP_16, 4'd3);
		run_phase(100, 1'b0);
		program_target($urandom, 16'd800, 12'd200, 12'd150, 6'd8, 4'd1);
		run_phase(100, 1'b0);
		program_target($urandom, 16'd4, 12'd1, 12'd1, BPP_32, 4'd2);
		run_phase(100, 1'b0);

		// long receiver hold-off while requests keep coming
		program_target($urandom, 16'd2048, 12'd512, 12'd256, BPP_32, 4'd7);
		hold_off_req = 1'b1;
		run_phase(150, 1'b1);

		for (int k = 0; k < 5; k++) begin
			wd = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(1, 4095)) :
				12'($urandom_range(1, 200));
			ht = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(1, 4095)) :
				12'($urandom_range(1, 200));
			if ($urandom_range(0, 7) == 0)
				depth = 6'($urandom);
			else
				depth = $urandom_range(0, 1) ? BPP_32 : BPP_16;
			program_target($urandom, 16'($urandom), wd, ht, depth, 4'($urandom));
			run_phase(140, k == 2);
		end

		drain();
		repeat (8) @(posedge clk);
		$display("covered %0d requests and %0d descriptors over %0d target settings",
			accepted, board.checked, settings);
		$display("descriptors: %0d copy, %0d no-copy, %0d rejected, %0d field mismatches",
			board.copies, board.no_copies, board.rejects, board.errors);
		if (board.errors == 0 && board.due_descriptors.size() == 0)
			$display("PASS blit_clip_descriptor");
		else
			$display("FAIL blit_clip_descriptor");
		$finish;
	end
endmodule
